FILE: sv/hasmtok_pkg.sv
// Shared types and constants for the assembly line tokenizer.
package hasmtok_pkg;

  localparam int CH_W          = 8;
  localparam int TEXT_W        = 24;
  localparam int TEXT_CNT_W    = 2;
  localparam int VAL_CNT_W     = 8;
  localparam int VALUE_MAX_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int OUT_DATA_W    = 88;

  localparam logic [TEXT_CNT_W-1:0] TEXT_MAX = 2'd3;

  // bit positions in the field valid marks
  localparam int MARK_DEST = 0;
  localparam int MARK_COMP = 1;
  localparam int MARK_JUMP = 2;

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_ONE    = 8'h31;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_AT     = 8'h40;
  localparam logic [CH_W-1:0] CH_A      = 8'h41;
  localparam logic [CH_W-1:0] CH_D      = 8'h44;
  localparam logic [CH_W-1:0] CH_M      = 8'h4D;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_BLANK,
    CC_NUL,
    CC_AT,
    CC_LPAREN,
    CC_RPAREN,
    CC_SLASH,
    CC_EQ,
    CC_SEMI,
    CC_CSTART
  } char_class_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_A,
    ST_C,
    ST_LABEL,
    ST_FVAL,
    ST_FINS,
    ST_SL1,
    ST_SL2
  } parse_st_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_A,
    K_C,
    K_LABEL
  } line_kind_t;

  typedef enum logic [1:0] {
    T_NONE,
    T_DEST,
    T_COMP,
    T_JUMP
  } target_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_CHAR,
    ERR_INCOMPLETE,
    ERR_TOO_LONG
  } err_t;

  // one classified character request on its way to the parser
  typedef struct packed {
    logic            line_end;
    char_class_t     cls;
    logic [CH_W-1:0] ch;
  } tok_t;

  // result payload, first member is the top bit
  typedef struct packed {
    logic              pad;
    logic              jump_present;
    logic [TEXT_W-1:0] jump_text;
    logic [TEXT_W-1:0] comp_text;
    logic              dest_present;
    logic [TEXT_W-1:0] dest_text;
    err_t              error_code;
    line_kind_t        instr_kind;
    logic              line_ok;
    logic [CH_W-1:0]   value_char;
  } out_data_t;

endpackage

FILE: sv/hasmtok_front.sv
// Front end: classifies each incoming character into a token request.
module hasmtok_front import hasmtok_pkg::*; (
  input  logic            in_tvalid,
  input  logic [CH_W-1:0] in_ch,
  input  logic            in_line_end,
  output logic            push_valid,
  output tok_t            push_tok
);

  char_class_t cls;

  always_comb begin
    unique case (in_ch) inside
      CH_SPACE, [CH_TAB:CH_CR]:                          cls = CC_BLANK;
      CH_NUL:                                            cls = CC_NUL;
      CH_AT:                                             cls = CC_AT;
      CH_LPAREN:                                         cls = CC_LPAREN;
      CH_RPAREN:                                         cls = CC_RPAREN;
      CH_SLASH:                                          cls = CC_SLASH;
      CH_EQ:                                             cls = CC_EQ;
      CH_SEMI:                                           cls = CC_SEMI;
      CH_ZERO, CH_ONE, CH_MINUS, CH_D, CH_A, CH_BANG, CH_M: cls = CC_CSTART;
      default:                                           cls = CC_OTHER;
    endcase
  end

  assign push_valid        = in_tvalid;
  assign push_tok.line_end = in_line_end;
  assign push_tok.cls      = cls;
  assign push_tok.ch       = in_ch;

endmodule

FILE: sv/hasmtok_queue.sv
// Short token queue between the classifier and the parser.
module hasmtok_queue import hasmtok_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  tok_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_tok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> rd_ptr_r != $past(rd_ptr_r) || DEPTH == 1)
    else $error("read pointer stuck on pop");

endmodule

FILE: sv/hasmtok_back.sv
// Back end: line parser state machine and result register.
module hasmtok_back import hasmtok_pkg::*; #(
  parameter int VALUE_MAX_LEN = VALUE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  tok_t                  tok,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [VAL_CNT_W-1:0] VAL_LIMIT = VAL_CNT_W'(VALUE_MAX_LEN);

  parse_st_t             st_r, st_nxt, st_w;
  line_kind_t            kind_r, kind_nxt, kind_w;
  target_t               tgt_r, tgt_nxt, tgt_w;
  logic [TEXT_W-1:0]     dest_r, dest_nxt, comp_r, comp_nxt, jump_r, jump_nxt;
  logic [TEXT_CNT_W-1:0] dest_cnt_r, dest_cnt_nxt;
  logic [TEXT_CNT_W-1:0] comp_cnt_r, comp_cnt_nxt;
  logic [TEXT_CNT_W-1:0] jump_cnt_r, jump_cnt_nxt;
  logic [2:0]            marks_r, marks_nxt, marks_w;
  logic [VAL_CNT_W-1:0]  value_cnt_r, value_cnt_nxt;
  err_t                  err_r, err_nxt, err_w, res_err;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_user_r, out_user_nxt;
  out_data_t             out_data_r, out_data_nxt;

  logic                  do_pop, emit_val, ld_line, tlen_nz;

  assign pop_ready = !out_valid_r || out_tready;
  assign do_pop    = pop_valid && pop_ready;

  // current A value or C field holds at least one character; always clear for a label
  always_comb begin
    tlen_nz = 1'b0;
    if (kind_r == K_A) begin
      tlen_nz = (value_cnt_r != '0);
    end else if (kind_r == K_C) begin
      case (tgt_r)
        T_DEST:  tlen_nz = (dest_cnt_r != '0);
        T_COMP:  tlen_nz = (comp_cnt_r != '0);
        T_JUMP:  tlen_nz = (jump_cnt_r != '0);
        default: tlen_nz = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    tgt_nxt       = tgt_r;
    dest_nxt      = dest_r;
    comp_nxt      = comp_r;
    jump_nxt      = jump_r;
    dest_cnt_nxt  = dest_cnt_r;
    comp_cnt_nxt  = comp_cnt_r;
    jump_cnt_nxt  = jump_cnt_r;
    marks_nxt     = marks_r;
    value_cnt_nxt = value_cnt_r;
    err_nxt       = err_r;
    st_w          = st_r;
    kind_w        = kind_r;
    tgt_w         = tgt_r;
    marks_w       = marks_r;
    err_w         = ERR_NONE;
    res_err       = err_r;
    emit_val      = 1'b0;
    ld_line       = 1'b0;

    if (do_pop) begin
      if (tok.line_end) begin
        ld_line = 1'b1;
        if (err_r == ERR_NONE && kind_r == K_C &&
            ((marks_r[MARK_DEST] && dest_cnt_r == '0) ||
             (marks_r[MARK_JUMP] && jump_cnt_r == '0) || comp_cnt_r == '0)) begin
          res_err = ERR_INCOMPLETE;
        end
        st_nxt        = ST_NONE;
        kind_nxt      = K_NONE;
        tgt_nxt       = T_NONE;
        dest_nxt      = '0;
        comp_nxt      = '0;
        jump_nxt      = '0;
        dest_cnt_nxt  = '0;
        comp_cnt_nxt  = '0;
        jump_cnt_nxt  = '0;
        marks_nxt     = '0;
        value_cnt_nxt = '0;
        err_nxt       = ERR_NONE;
      end else if (err_r == ERR_NONE && st_r != ST_SL2) begin
        unique case (tok.cls)
          CC_NUL: begin
            st_nxt = ST_SL2;
          end
          CC_AT, CC_LPAREN: begin
            if (st_r == ST_NONE) begin
              st_nxt   = (tok.cls == CC_AT) ? ST_A : ST_LABEL;
              kind_nxt = (tok.cls == CC_AT) ? K_A : K_LABEL;
            end else begin
              err_w = ERR_CHAR;
            end
          end
          CC_RPAREN: begin
            if (st_r == ST_LABEL || st_r == ST_FVAL) st_nxt = ST_FINS;
            else err_w = ERR_CHAR;
          end
          CC_SLASH: begin
            if (st_r == ST_SL1) begin
              st_nxt = ST_SL2;
            end else if (st_r == ST_FINS || st_r == ST_NONE) begin
              st_nxt = ST_SL1;
            end else if ((st_r == ST_C || st_r == ST_FVAL) && kind_r == K_C) begin
              st_nxt = ST_SL1;
            end else begin
              err_w = ERR_CHAR;
            end
          end
          default: begin
            // a dest/comp opener starts a C-instruction
            if (st_r == ST_NONE && tok.cls == CC_CSTART) begin
              st_w              = ST_C;
              kind_w            = K_C;
              tgt_w             = T_DEST;
              marks_w[MARK_DEST] = 1'b1;
            end
            st_nxt    = st_w;
            kind_nxt  = kind_w;
            tgt_nxt   = tgt_w;
            marks_nxt = marks_w;
            if (tok.cls == CC_BLANK) begin
              if (tlen_nz) begin
                if (st_r == ST_A) st_nxt = ST_FINS;
                else if (st_r == ST_C || st_r == ST_LABEL) st_nxt = ST_FVAL;
                else if (st_r == ST_SL1) err_w = ERR_CHAR;
              end
            end else if (st_w == ST_LABEL || st_w == ST_A) begin
              if (value_cnt_r >= VAL_LIMIT) begin
                err_w = ERR_TOO_LONG;
              end else begin
                value_cnt_nxt = value_cnt_r + 1'b1;
                emit_val      = 1'b1;
              end
            end else if ((st_w == ST_FVAL && kind_w == K_C) || st_w == ST_C) begin
              if (tok.cls == CC_EQ) begin
                if (tgt_w != T_DEST) begin
                  err_w = ERR_CHAR;
                end else begin
                  st_nxt               = ST_C;
                  tgt_nxt              = T_COMP;
                  marks_nxt[MARK_COMP] = 1'b1;
                end
              end else if (tok.cls == CC_SEMI) begin
                if (tgt_w == T_DEST || tgt_w == T_COMP) begin
                  // no '=' seen: the gathered dest text is really comp
                  if (tgt_w == T_DEST) begin
                    comp_nxt             = dest_r;
                    comp_cnt_nxt         = dest_cnt_r;
                    dest_nxt             = '0;
                    dest_cnt_nxt         = '0;
                    marks_nxt[MARK_COMP] = 1'b1;
                    marks_nxt[MARK_DEST] = 1'b0;
                  end
                  st_nxt               = ST_C;
                  tgt_nxt              = T_JUMP;
                  marks_nxt[MARK_JUMP] = 1'b1;
                end else begin
                  err_w = ERR_CHAR;
                end
              end else if (st_w != ST_C) begin
                err_w = ERR_CHAR;
              end else if (tgt_w == T_DEST && dest_cnt_r != TEXT_MAX) begin
                dest_nxt     = dest_r | (TEXT_W'(tok.ch) << {dest_cnt_r, 3'b000});
                dest_cnt_nxt = dest_cnt_r + 1'b1;
              end else if (tgt_w == T_COMP && comp_cnt_r != TEXT_MAX) begin
                comp_nxt     = comp_r | (TEXT_W'(tok.ch) << {comp_cnt_r, 3'b000});
                comp_cnt_nxt = comp_cnt_r + 1'b1;
              end else if (tgt_w == T_JUMP && jump_cnt_r != TEXT_MAX) begin
                jump_nxt     = jump_r | (TEXT_W'(tok.ch) << {jump_cnt_r, 3'b000});
                jump_cnt_nxt = jump_cnt_r + 1'b1;
              end else begin
                err_w = ERR_CHAR;
              end
            end else begin
              err_w = ERR_CHAR;
            end
          end
        endcase
        err_nxt = err_w;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    if (emit_val || ld_line) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = ld_line;
      out_data_nxt  = '0;
      if (ld_line) begin
        out_data_nxt.line_ok      = (res_err == ERR_NONE);
        out_data_nxt.instr_kind   = kind_r;
        out_data_nxt.error_code   = res_err;
        out_data_nxt.dest_text    = dest_r;
        out_data_nxt.dest_present = marks_r[MARK_DEST];
        out_data_nxt.comp_text    = comp_r;
        out_data_nxt.jump_text    = jump_r;
        out_data_nxt.jump_present = marks_r[MARK_JUMP];
      end else begin
        out_data_nxt.value_char = tok.ch;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_NONE;
      kind_r      <= K_NONE;
      tgt_r       <= T_NONE;
      dest_r      <= '0;
      comp_r      <= '0;
      jump_r      <= '0;
      dest_cnt_r  <= '0;
      comp_cnt_r  <= '0;
      jump_cnt_r  <= '0;
      marks_r     <= '0;
      value_cnt_r <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      kind_r      <= kind_nxt;
      tgt_r       <= tgt_nxt;
      dest_r      <= dest_nxt;
      comp_r      <= comp_nxt;
      jump_r      <= jump_nxt;
      dest_cnt_r  <= dest_cnt_nxt;
      comp_cnt_r  <= comp_cnt_nxt;
      jump_cnt_r  <= jump_cnt_nxt;
      marks_r     <= marks_nxt;
      value_cnt_r <= value_cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && tok.line_end |=>
      st_r == ST_NONE && err_r == ERR_NONE && marks_r == '0 && value_cnt_r == '0)
    else $error("line state not cleared after line end");

  a_value_bound: assert property (@(posedge clk) disable iff (!rst_n)
    value_cnt_r <= VAL_LIMIT)
    else $error("value length beyond limit");

  // a popped token after an error adds nothing, and the result slot was free or drained
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !tok.line_end && err_r != ERR_NONE |=> !out_valid_r)
    else $error("value request emitted after an error");

  a_no_text_without_c: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r != K_C |-> dest_r == '0 && comp_r == '0 && jump_r == '0)
    else $error("instruction text held outside a C line");

endmodule

FILE: sv/hack_asm_line_tokenizer.sv
// Top level of the assembly line tokenizer.
//
// Takes one source character per request (in_tlast marks the line-end request, whose
// character is ignored) and sorts the line into an A-instruction, a label or a
// C-instruction. Each character added to an A value or label name leaves at once as a
// value result (out_tuser = 0); the line-end request gives the line result
// (out_tuser = 1) with status, kind, error code and the dest/comp/jump texts. Other
// characters give no result. The block takes one character every clock while results
// drain: a classifier feeds a two-entry token queue, the parser consumes one token per
// cycle, and a result register holds its output. A request is written into the queue,
// and its result is loaded into the result register when the parser pops it. While a
// result waits the parser stops, the queue fills its two entries, and then in_tready
// drops until the result is taken.
module hack_asm_line_tokenizer import hasmtok_pkg::*; #(
  parameter int VALUE_MAX_LEN = VALUE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CH_W-1:0]       in_tdata,   // [7:0] ch
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value_char, line_ok, instr_kind, error_code,
                                            // dest_text, dest_present, comp_text,
                                            // jump_text, jump_present, zero pad
  output logic                  out_tuser   // [0] result_kind
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  tok_t push_tok, pop_tok;

  hasmtok_front u_front (
    .in_tvalid   (in_tvalid),
    .in_ch       (in_tdata),
    .in_line_end (in_tlast),
    .push_valid  (push_valid),
    .push_tok    (push_tok)
  );

  hasmtok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  hasmtok_back #(
    .VALUE_MAX_LEN (VALUE_MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .tok        (pop_tok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  assign in_tready = push_ready;

endmodule

FILE: dv/hack_asm_line_tokenizer_tb.sv
// Testbench for hack_asm_line_tokenizer: directed table, then predictor-checked random lines.
module hack_asm_line_tokenizer_tb import hasmtok_pkg::*;;

  localparam int VAL_MAX = VALUE_MAX_DEF;
  localparam int RAND_ITEMS = 1050;

  typedef struct packed {
    logic      is_line;
    out_data_t d;
  } tok_result_t;

  // directed row: character, line end, then the typed-in result where there is one
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic        is_line;
    logic [7:0]  vch;
    logic        ok;
    line_kind_t  kind;
    err_t        err;
    logic [23:0] dest;
    logic        dest_p;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [27] = '{
    // empty line right after reset
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b1, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_AT,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{"5",       1'b0, 1'b1, 1'b0, "5",   1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b1, K_A,     ERR_NONE,       24'h0,      1'b0},
    // comp moved over by ';'
    '{CH_ZERO,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_SEMI,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{"J",       1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    // dest=comp followed by a comment
    '{CH_M,      1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_EQ,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_D,      1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    // label with a blank after the name
    '{CH_LPAREN, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{"X",       1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_RPAREN, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_RPAREN, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, K_NONE,  ERR_CHAR,       24'h0,      1'b0},
    // dest only, comp missing
    '{CH_D,      1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, K_C,     ERR_INCOMPLETE, 24'h000044, 1'b1},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b1, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{8'hFF,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, K_NONE,  ERR_NONE,       24'h0,      1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, K_NONE,  ERR_CHAR,       24'h0,      1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CH_W-1:0]       in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic        row_typed = 1'b0;
  tok_result_t row_fixed = '0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        pressure_go = 1'b0;
  logic        pressure_done = 1'b0;
  int          hold_left = 0;
  int          sent_cnt = 0;
  int          fail_cnt = 0;

  tok_result_t expected_tokens[$];

  // predictor state
  parse_st_t   tk_st;
  line_kind_t  tk_kind;
  target_t     tk_tgt;
  logic [23:0] tk_dest, tk_comp, tk_jump;
  logic [1:0]  tk_dcnt, tk_ccnt, tk_jcnt;
  logic [2:0]  tk_marks;
  logic [7:0]  tk_vcnt;
  err_t        tk_err;

  string ID_POOL  = "abzAZ_.$:09QmR";
  string C_START  = "01-DAM!";
  string C_POOL   = "ADM01-+!&|";
  string JMP_POOL = "JMPGTEQLN";

  hack_asm_line_tokenizer #(
    .VALUE_MAX_LEN(VAL_MAX)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_line_state();
    tk_st = ST_NONE;
    tk_kind = K_NONE;
    tk_tgt = T_NONE;
    tk_dest = '0;
    tk_comp = '0;
    tk_jump = '0;
    tk_dcnt = '0;
    tk_ccnt = '0;
    tk_jcnt = '0;
    tk_marks = '0;
    tk_vcnt = '0;
    tk_err = ERR_NONE;
  endtask

  function automatic int held_len();
    if (tk_kind == K_A) return int'(tk_vcnt);
    if (tk_kind != K_C) return 0;
    case (tk_tgt)
      T_DEST:  return int'(tk_dcnt);
      T_COMP:  return int'(tk_ccnt);
      T_JUMP:  return int'(tk_jcnt);
      default: return 0;
    endcase
  endfunction

  task automatic tokenize_c_field(input logic [7:0] c, output err_t e);
    e = ERR_NONE;
    if (c == CH_EQ) begin
      if (tk_tgt != T_DEST) begin
        e = ERR_CHAR;
      end else begin
        tk_st = ST_C;
        tk_marks[MARK_COMP] = 1'b1;
        tk_tgt = T_COMP;
      end
    end else if (c == CH_SEMI) begin
      // a text gathered as dest was really the comp
      if (tk_tgt == T_DEST) begin
        tk_comp = tk_dest;
        tk_ccnt = tk_dcnt;
        tk_marks[MARK_COMP] = 1'b1;
        tk_marks[MARK_DEST] = 1'b0;
        tk_dest = '0;
        tk_dcnt = '0;
      end
      if (tk_tgt == T_DEST || tk_tgt == T_COMP) begin
        tk_st = ST_C;
        tk_tgt = T_JUMP;
        tk_marks[MARK_JUMP] = 1'b1;
      end else begin
        e = ERR_CHAR;
      end
    end else if (tk_st != ST_C) begin
      e = ERR_CHAR;
    end else if (tk_tgt == T_DEST && tk_dcnt < TEXT_MAX) begin
      tk_dest[8*tk_dcnt +: 8] = c;
      tk_dcnt = tk_dcnt + 1'b1;
    end else if (tk_tgt == T_COMP && tk_ccnt < TEXT_MAX) begin
      tk_comp[8*tk_ccnt +: 8] = c;
      tk_ccnt = tk_ccnt + 1'b1;
    end else if (tk_tgt == T_JUMP && tk_jcnt < TEXT_MAX) begin
      tk_jump[8*tk_jcnt +: 8] = c;
      tk_jcnt = tk_jcnt + 1'b1;
    end else begin
      e = ERR_CHAR;
    end
  endtask

  task automatic tokenize_char(input logic [7:0] c, input logic eol, output logic emit,
                               output tok_result_t r);
    err_t e;
    logic blank;
    logic c_start;
    emit = 1'b0;
    r = '0;
    e = ERR_NONE;
    if (eol) begin
      e = tk_err;
      if (e == ERR_NONE && tk_kind == K_C &&
          ((tk_marks[MARK_DEST] && tk_dcnt == 0) ||
           (tk_marks[MARK_JUMP] && tk_jcnt == 0) || tk_ccnt == 0))
        e = ERR_INCOMPLETE;
      emit = 1'b1;
      r.is_line = 1'b1;
      r.d.line_ok = (e == ERR_NONE);
      r.d.instr_kind = tk_kind;
      r.d.error_code = e;
      r.d.dest_text = tk_dest;
      r.d.dest_present = tk_marks[MARK_DEST];
      r.d.comp_text = tk_comp;
      r.d.jump_text = tk_jump;
      r.d.jump_present = tk_marks[MARK_JUMP];
      clear_line_state();
      return;
    end
    if (tk_err != ERR_NONE || tk_st == ST_SL2) return;
    // a zero byte ends the text; the check at line end still runs
    if (c == CH_NUL) begin
      tk_st = ST_SL2;
      return;
    end
    blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    c_start = (c == CH_ZERO || c == CH_ONE || c == CH_MINUS || c == CH_D ||
               c == CH_A || c == CH_BANG || c == CH_M);
    if (c == CH_AT || c == CH_LPAREN) begin
      if (tk_st == ST_NONE) begin
        tk_st = (c == CH_AT) ? ST_A : ST_LABEL;
        tk_kind = (c == CH_AT) ? K_A : K_LABEL;
      end else begin
        e = ERR_CHAR;
      end
    end else if (c == CH_RPAREN) begin
      if (tk_st == ST_LABEL || tk_st == ST_FVAL) tk_st = ST_FINS;
      else e = ERR_CHAR;
    end else if (c == CH_SLASH) begin
      if (tk_st == ST_SL1) tk_st = ST_SL2;
      else if (tk_st == ST_FINS || tk_st == ST_NONE) tk_st = ST_SL1;
      else if ((tk_st == ST_C || tk_st == ST_FVAL) && tk_kind == K_C) tk_st = ST_SL1;
      else e = ERR_CHAR;
    end else begin
      if (tk_st == ST_NONE && c_start) begin
        tk_st = ST_C;
        tk_kind = K_C;
        tk_marks[MARK_DEST] = 1'b1;
        tk_tgt = T_DEST;
      end
      if (blank) begin
        // blanks end a value only once it holds something; label names never end here
        if (held_len() != 0) begin
          if (tk_st == ST_A) tk_st = ST_FINS;
          else if (tk_st == ST_C || tk_st == ST_LABEL) tk_st = ST_FVAL;
          else if (tk_st == ST_SL1) e = ERR_CHAR;
        end
      end else if (tk_st == ST_LABEL || tk_st == ST_A) begin
        if (tk_vcnt >= VAL_MAX) begin
          e = ERR_TOO_LONG;
        end else begin
          tk_vcnt = tk_vcnt + 1'b1;
          emit = 1'b1;
          r.d.value_char = c;
          return;
        end
      end else if ((tk_st == ST_FVAL && tk_kind == K_C) || tk_st == ST_C) begin
        tokenize_c_field(c, e);
      end else begin
        e = ERR_CHAR;
      end
    end
    tk_err = e;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [23:0] g, input logic [23:0] w);
    if (g !== w) flag_mismatch($sformatf("%s got %h, expected %h", name, g, w));
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_blank();
    int v;
    v = $urandom_range(9, 14);
    return (v == 14) ? CH_SPACE : 8'(v);
  endfunction

  task automatic send_req(input logic [7:0] c, input logic last, input logic typed,
                          input tok_result_t fixed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    row_typed <= typed;
    row_fixed <= fixed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_line();
    logic [7:0] ln[$];
    int sel;
    int n;
    int k;
    sel = $urandom_range(99);
    if (sel < 25) begin
      ln.push_back(CH_AT);
      n = ($urandom_range(29) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      repeat (n) ln.push_back(pick(ID_POOL));
    end else if (sel < 45) begin
      ln.push_back(CH_LPAREN);
      n = $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(7) == 0) ln.push_back(pick_blank());
        ln.push_back(pick(ID_POOL));
      end
      ln.push_back(CH_RPAREN);
    end else if (sel < 80) begin
      if ($urandom_range(3) == 0) ln.push_back(pick_blank());
      if ($urandom_range(1) == 1) begin
        n = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
        ln.push_back(pick(C_START));
        repeat (n - 1) ln.push_back(pick(C_POOL));
        if ($urandom_range(6) == 0) ln.push_back(pick_blank());
        ln.push_back(CH_EQ);
        if ($urandom_range(6) == 0) ln.push_back(pick_blank());
        n = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) ln.push_back(pick(C_POOL));
      end else begin
        n = $urandom_range(1, 3);
        ln.push_back(pick(C_START));
        repeat (n - 1) ln.push_back(pick(C_POOL));
      end
      if ($urandom_range(1) == 1) begin
        if ($urandom_range(6) == 0) ln.push_back(pick_blank());
        ln.push_back(CH_SEMI);
        n = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 3);
        if ($urandom_range(19) == 0) n = 4;
        repeat (n) ln.push_back(pick(JMP_POOL));
      end
    end else if (sel < 88) begin
      n = $urandom_range(0, 3);
      repeat (n) ln.push_back(pick_blank());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) ln.push_back(8'($urandom_range(255)));
    end
    if (sel < 88) begin
      if ($urandom_range(2) == 0) ln.push_back(pick_blank());
      if ($urandom_range(3) == 0 || sel >= 80) begin
        ln.push_back(CH_SLASH);
        ln.push_back(CH_SLASH);
        n = $urandom_range(0, 5);
        repeat (n) ln.push_back(8'($urandom_range(255)));
      end
    end
    // corrupt some lines
    if (ln.size() != 0 && $urandom_range(99) < 8)
      ln[$urandom_range(ln.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 3) begin
      ln.insert($urandom_range(ln.size()), CH_NUL);
      n = $urandom_range(0, 3);
      repeat (n) ln.push_back(8'($urandom_range(255)));
    end
    foreach (ln[k]) send_req(ln[k], 1'b0, 1'b0, '0);
    send_req(8'($urandom_range(255)), 1'b1, 1'b0, '0);
  endtask

  // receiver side, with one long hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_go && !pressure_done) begin
      out_tready <= 1'b0;
      hold_left <= 300;
      pressure_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic        hit;
    tok_result_t pred;
    if (rst_n && in_tvalid && in_tready) begin
      tokenize_char(in_tdata, in_tlast, hit, pred);
      if (hit) expected_tokens.push_back(row_typed ? row_fixed : pred);
    end
  end

  always @(posedge clk) begin
    tok_result_t got;
    tok_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_line = out_tuser;
      got.d = out_tdata;
      if (expected_tokens.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: kind %0d data %h",
                                out_tuser, out_tdata));
      end else begin
        want = expected_tokens.pop_front();
        check_field("result_kind", 24'(got.is_line), 24'(want.is_line));
        check_field("value_char", 24'(got.d.value_char), 24'(want.d.value_char));
        check_field("line_ok", 24'(got.d.line_ok), 24'(want.d.line_ok));
        check_field("instr_kind", 24'(got.d.instr_kind), 24'(want.d.instr_kind));
        check_field("error_code", 24'(got.d.error_code), 24'(want.d.error_code));
        check_field("dest_text", got.d.dest_text, want.d.dest_text);
        check_field("dest_present", 24'(got.d.dest_present), 24'(want.d.dest_present));
        check_field("comp_text", got.d.comp_text, want.d.comp_text);
        check_field("jump_text", got.d.jump_text, want.d.jump_text);
        check_field("jump_present", 24'(got.d.jump_present), 24'(want.d.jump_present));
        check_field("pad", 24'(got.d.pad), 24'(want.d.pad));
      end
    end
  end

  initial begin
    tok_result_t fixed;
    clear_line_state();
    tx_idle_pct = 18;
    rx_idle_pct <= 66;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 27; i++) begin
      fixed = '0;
      fixed.is_line = DIR_TAB[i].is_line;
      fixed.d.value_char = DIR_TAB[i].vch;
      fixed.d.line_ok = DIR_TAB[i].ok;
      fixed.d.instr_kind = DIR_TAB[i].kind;
      fixed.d.error_code = DIR_TAB[i].err;
      fixed.d.dest_text = DIR_TAB[i].dest;
      fixed.d.dest_present = DIR_TAB[i].dest_p;
      send_req(DIR_TAB[i].ch, DIR_TAB[i].last, DIR_TAB[i].typed, fixed);
    end
    sent_cnt = 0;
    while (sent_cnt < RAND_ITEMS) begin
      if (sent_cnt >= 700) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        pressure_go <= 1'b1;
      end else if (sent_cnt >= 350) begin
        tx_idle_pct = 66;
        rx_idle_pct <= 18;
      end
      send_line();
    end
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
